@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/agla_pkg.sv @@
// Shared types and codes for the affine-gap local alignment block.
// No dependencies.
package agla_pkg;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_STREAM = 1'b1;

	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP_OPEN = 2'd2;
	localparam logic [1:0] REG_GAP_EXT  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;   // store a query symbol
		logic start;  // begin a database row
		logic step;   // issue next column read
		logic emit;   // move row best to output register
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic last_issue;
		logic out_busy;
	} status_t;

endpackage

@@ hdl/affine_gap_local_alignment_rows_top.sv @@
// Top level of the affine-gap local alignment row engine.
// Depends on agla_pkg, agla_ctrl and agla_dp.
//
// Query symbols load one beat each (tuser[0]=0, tuser[1] starts a new query);
// a database beat (tuser[0]=1, tuser[1] clears the stored rows) sweeps the
// stored query one column per cycle through a single cell update unit and
// gives one row_best beat; an empty query answers 0. The finished result
// sits in an output register, so a new beat is taken while it waits.
module affine_gap_local_alignment_rows_top import agla_pkg::*; #(
	parameter int MAX_QUERY  = 64,
	parameter int SCORE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [0] action, [1] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [15:0] row_best
);

	cmd_t    cmd;
	status_t st;

	agla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser[0]),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	agla_dp #(
		.MAX_QUERY  (MAX_QUERY),
		.SCORE_BITS (SCORE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.symbol    (s_tdata),
		.restart   (s_tuser[1]),
		.cmd       (cmd),
		.st        (st),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule

@@ hdl/agla_ctrl.sv @@
// Sequencer for load, row sweep and result hand-off.
// Depends on agla_pkg.
module agla_ctrl import agla_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    action,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (action == ACT_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = st.len_zero ? ST_EMIT : ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (st.last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hdl/agla_dp.sv @@
// Datapath: config registers, query and row memories, one cell update per cycle.
// Depends on agla_pkg.
module agla_dp import agla_pkg::*; #(
	parameter int MAX_QUERY  = 64,
	parameter int SCORE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic [7:0]  symbol,
	input  logic        restart,
	input  cmd_t        cmd,
	output status_t     st,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [15:0] m_tdata
);

	localparam int AW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
	localparam int LW = $clog2(MAX_QUERY + 1);
	localparam int SB = SCORE_BITS;
	localparam int SW = SCORE_BITS + 2;

	logic signed [7:0] match_q, mismatch_q, gap_open_q, gap_ext_q;
	logic [LW-1:0]     qlen_q;
	logic              rows_ok_q, use_rows_q;
	logic [7:0]        sym_q;
	logic [AW-1:0]     rd_cnt_q;

	logic [7:0]    qmem [MAX_QUERY];
	logic [SB-1:0] hmem [MAX_QUERY];
	logic [SB-1:0] fmem [MAX_QUERY];

	logic [7:0]    q_rd_s1;
	logic [SB-1:0] h_rd_s1, f_rd_s1;
	logic [AW-1:0] col_s1;
	logic          vld_s1;

	logic [SB-1:0] diag_q, lh_q, le_q, best_q;
	logic          out_vld_q;
	logic [15:0]   out_q;

	function automatic logic signed [SW-1:0] sx8(input logic signed [7:0] v);
		return {{(SW-8){v[7]}}, v};
	endfunction

	function automatic logic signed [SW-1:0] ux(input logic [SB-1:0] v);
		return {2'b00, v};
	endfunction

	function automatic logic [SB-1:0] clampv(input logic signed [SW-1:0] v);
		if (v < 0) return '0;
		else if (v > ux({SB{1'b1}})) return {SB{1'b1}};
		else return v[SB-1:0];
	endfunction

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= 8'sd2;
			mismatch_q <= -8'sd1;
			gap_open_q <= -8'sd3;
			gap_ext_q  <= -8'sd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATCH:    match_q    <= cfg_data;
				REG_MISMATCH: mismatch_q <= cfg_data;
				REG_GAP_OPEN: gap_open_q <= cfg_data;
				REG_GAP_EXT:  gap_ext_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LW-1:0] qlen_eff;
	logic          room;
	assign qlen_eff = restart ? '0 : qlen_q;
	assign room     = qlen_eff < LW'(MAX_QUERY);

	// rows written in full by every row sweep, so one flag tracks their validity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q     <= '0;
			rows_ok_q  <= 1'b0;
			use_rows_q <= 1'b0;
			rd_cnt_q   <= '0;
			vld_s1     <= 1'b0;
		end else begin
			vld_s1 <= cmd.step;
			if (cmd.load) begin
				rows_ok_q <= 1'b0;
				qlen_q    <= room ? qlen_eff + 1'b1 : qlen_eff;
			end
			if (cmd.start) begin
				use_rows_q <= rows_ok_q & ~restart;
				if (qlen_q != '0) rows_ok_q <= 1'b1;
				rd_cnt_q <= '0;
			end else if (cmd.step) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && room) qmem[qlen_eff[AW-1:0]] <= symbol;
		if (cmd.start) sym_q <= symbol;
	end

	always_ff @(posedge clk) begin
		q_rd_s1 <= qmem[rd_cnt_q];
		h_rd_s1 <= hmem[rd_cnt_q];
		f_rd_s1 <= fmem[rd_cnt_q];
		col_s1  <= rd_cnt_q;
	end

	// cell update
	logic [SB-1:0]        up_h, up_f, f_new, e_new, h_new;
	logic signed [SW-1:0] f_a, f_b, e_a, e_b, d_s, m_ef, m_h;
	always_comb begin
		up_h  = use_rows_q ? h_rd_s1 : '0;
		up_f  = use_rows_q ? f_rd_s1 : '0;
		f_a   = ux(up_h) + sx8(gap_open_q);
		f_b   = ux(up_f) + sx8(gap_ext_q);
		f_new = clampv((f_a > f_b) ? f_a : f_b);
		e_a   = ux(lh_q) + sx8(gap_open_q);
		e_b   = ux(le_q) + sx8(gap_ext_q);
		e_new = clampv((e_a > e_b) ? e_a : e_b);
		d_s   = ux(diag_q) + sx8((q_rd_s1 == sym_q) ? match_q : mismatch_q);
		m_ef  = (e_new > f_new) ? ux(e_new) : ux(f_new);
		m_h   = (d_s > m_ef) ? d_s : m_ef;
		h_new = clampv(m_h);
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hmem[col_s1] <= h_new;
			fmem[col_s1] <= f_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			diag_q <= '0;
			lh_q   <= '0;
			le_q   <= '0;
			best_q <= '0;
		end else if (vld_s1) begin
			diag_q <= up_h;
			lh_q   <= h_new;
			le_q   <= e_new;
			if (h_new > best_q) best_q <= h_new;
		end
	end

	logic [SB+15:0] best_w;
	assign best_w = {16'b0, best_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_q <= (best_w > (SB+16)'(65535)) ? 16'hFFFF : best_w[15:0];
	end

	assign m_tvalid      = out_vld_q;
	assign m_tdata       = out_q;
	assign st.len_zero   = (qlen_q == '0);
	assign st.last_issue = (LW'(rd_cnt_q) == qlen_q - 1'b1);
	assign st.out_busy   = out_vld_q & ~m_tready;

endmodule

@@ hdl/agla_checker.sv @@
// Port-level checks for the alignment row engine, bound to the top level.
// Depends on assert_macros.svh and agla_pkg.
`include "assert_macros.svh"

module agla_checker import agla_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic s_beat;
	assign s_beat = s_tvalid & s_tready;

	`AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`AST_NEXT(a_stream_busy, s_beat && s_tuser[0] == ACT_STREAM, !s_tready)
	`AST_NEXT(a_load_no_out, s_beat && s_tuser[0] == ACT_LOAD && !m_tvalid, !m_tvalid)

endmodule

bind affine_gap_local_alignment_rows_top agla_checker u_agla_checker (.*);

@@ sim/affine_gap_local_alignment_rows_top_tb.sv @@
// Self-checking testbench for the affine-gap local alignment row engine.
// Depends on agla_pkg and affine_gap_local_alignment_rows_top; drives query loads and database
// beats, predicts every row_best beat and compares it in order.
`timescale 1ns / 1ps

module affine_gap_local_alignment_rows_top_tb;
	import agla_pkg::*;

	localparam int QMAX = 64;
	localparam int SMAX = 65535;
	localparam int NUM_RANDOM = 306;

	typedef struct {
		logic       act;
		logic [7:0] sym;
		logic       rst;
		int         exp_best;  // -1: take from the row predictor
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	affine_gap_local_alignment_rows_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	int         w_match, w_mism, w_open, w_ext;
	logic [7:0] qsym [QMAX];
	int         qlen;
	int         row_h [QMAX];
	int         row_f [QMAX];
	int         best_q [$];

	int send_idle_pct, recv_idle_pct;
	bit hold_recv;
	int errors, n_beats_in, n_beats_out, n_loads;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic int clampv(int v);
		if (v < 0) return 0;
		if (v > SMAX) return SMAX;
		return v;
	endfunction

	function automatic int max3(int a, int b, int c);
		int m;
		m = a > b ? a : b;
		return m > c ? m : c;
	endfunction

	function automatic void clear_rows();
		for (int j = 0; j < QMAX; j++) begin
			row_h[j] = 0;
			row_f[j] = 0;
		end
	endfunction

	// one database row against the stored query; returns row best
	function automatic int align_row(logic [7:0] sym, logic rst);
		int diag, lh, le, best, upd, s, f, e, h;
		diag = 0; lh = 0; le = 0; best = 0;
		if (rst) clear_rows();
		for (int j = 0; j < qlen; j++) begin
			upd = row_h[j];
			s = (qsym[j] == sym) ? w_match : w_mism;
			f = clampv(max3(upd + w_open, row_f[j] + w_ext, 0));
			e = clampv(max3(lh + w_open, le + w_ext, 0));
			h = clampv(max3(diag + s, e, f));
			row_f[j] = f;
			row_h[j] = h;
			diag = upd; lh = h; le = e;
			if (h > best) best = h;
		end
		return best > SMAX ? SMAX : best;
	endfunction

	function automatic int predict(beat_t b);
		if (b.act == ACT_LOAD) begin
			if (b.rst) qlen = 0;
			if (qlen < QMAX) begin
				qsym[qlen] = b.sym;
				qlen++;
			end
			clear_rows();
			return -1;
		end
		return align_row(b.sym, b.rst);
	endfunction

	task automatic send(beat_t b);
		int best;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b.sym;
		s_tuser  <= {b.rst, b.act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		best = predict(b);
		if (b.act == ACT_STREAM) begin
			if (b.exp_best >= 0 && b.exp_best != best) begin
				errors++;
				if (errors <= 10)
					$display("directed row: table says %0d, predictor %0d", b.exp_best, best);
			end
			best_q.push_back(best);
			n_beats_in++;
		end else begin
			n_loads++;
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_MATCH:    w_match = $signed(val);
			REG_MISMATCH: w_mism  = $signed(val);
			REG_GAP_OPEN: w_open  = $signed(val);
			default:      w_ext   = $signed(val);
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (best_q.size() != 0) @(posedge clk);
		repeat (QMAX + 8) @(posedge clk);
	endtask

	task automatic set_weights(int m, int mm, int go, int ge);
		drain();
		write_reg(REG_MATCH, m[7:0]);
		write_reg(REG_MISMATCH, mm[7:0]);
		write_reg(REG_GAP_OPEN, go[7:0]);
		write_reg(REG_GAP_EXT, ge[7:0]);
		cfg_we <= 1'b0;
	endtask

	function automatic beat_t mk(logic act, logic [7:0] sym, logic rst, int eb);
		beat_t b;
		b.act = act; b.sym = sym; b.rst = rst; b.exp_best = eb;
		return b;
	endfunction

	// result side: random stall, in-order compare
	always @(posedge clk) begin
		int want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (best_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("row_best beat %0h with nothing expected", m_tdata);
				end else begin
					want = best_q.pop_front();
					n_beats_out++;
					if (m_tdata !== want[15:0]) begin
						errors++;
						if (errors <= 10)
							$display("row_best mismatch: expected %0d, got %0d", want, m_tdata);
					end
				end
			end
			m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		#50_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic random_phase(int count);
		int qn;
		beat_t b;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(9))
				0: begin
					// new query, mostly short, sometimes at or just past the store limit
					qn = ($urandom_range(7) == 0) ? QMAX + $urandom_range(2) : $urandom_range(1, 10);
					for (int j = 0; j < qn; j++)
						send(mk(ACT_LOAD, 8'($urandom_range(3)), j == 0, -1));
				end
				1: send(mk(ACT_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)), -1));
				2: send(mk(ACT_STREAM, 8'($urandom_range(255)), 1'($urandom_range(1)), -1));
				default: send(mk(ACT_STREAM, 8'($urandom_range(3)), $urandom_range(9) == 0, -1));
			endcase
		end
	endtask

	initial begin
		beat_t dir [$];
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		hold_recv = 1'b0;
		errors = 0; n_beats_in = 0; n_beats_out = 0; n_loads = 0;
		w_match = 2; w_mism = -1; w_open = -3; w_ext = -1;
		qlen = 0;
		clear_rows();
		send_idle_pct = 38; recv_idle_pct = 81;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty query answers zero; then a short query with known scores
		dir.push_back(mk(ACT_STREAM, 8'h00, 1'b0, 0));
		dir.push_back(mk(ACT_STREAM, 8'hFF, 1'b1, 0));
		dir.push_back(mk(ACT_LOAD, 8'h41, 1'b1, -1));
		dir.push_back(mk(ACT_LOAD, 8'hFF, 1'b0, -1));
		dir.push_back(mk(ACT_LOAD, 8'h00, 1'b0, -1));
		dir.push_back(mk(ACT_STREAM, 8'h41, 1'b1, 2));
		dir.push_back(mk(ACT_STREAM, 8'hFF, 1'b0, 4));
		dir.push_back(mk(ACT_STREAM, 8'h00, 1'b0, 6));
		dir.push_back(mk(ACT_STREAM, 8'h7E, 1'b0, -1));
		dir.push_back(mk(ACT_STREAM, 8'h41, 1'b1, 2));
		dir.push_back(mk(ACT_STREAM, 8'h80, 1'b0, -1));
		foreach (dir[i]) send(dir[i]);
		// fill the store past its limit: extra loads are dropped
		for (int j = 0; j < QMAX + 2; j++) send(mk(ACT_LOAD, 8'(j), j == 0, -1));
		send(mk(ACT_STREAM, 8'h05, 1'b1, 2));
		send(mk(ACT_STREAM, 8'h06, 1'b0, 4));

		// saturation: every weight at its largest value, so gaps add to the score
		set_weights(127, 127, 127, 127);
		for (int j = 0; j < QMAX; j++) send(mk(ACT_LOAD, 8'hAA, j == 0, -1));
		repeat (12) send(mk(ACT_STREAM, 8'hAA, 1'b0, -1));
		set_weights(-128, -128, -128, -128);
		send(mk(ACT_STREAM, 8'hAA, 1'b1, 0));
		set_weights(2, -1, -3, -1);

		random_phase(NUM_RANDOM / 3);
		set_weights($urandom_range(1, 20), -$urandom_range(0, 10), -$urandom_range(0, 12),
			-$urandom_range(0, 4));
		send_idle_pct = 81; recv_idle_pct = 38;
		random_phase(NUM_RANDOM / 3);

		// long receiver hold-off while beats keep arriving
		send_idle_pct = 0; recv_idle_pct = 0;
		fork
			begin
				hold_recv = 1'b1;
				repeat (400) @(posedge clk);
				hold_recv = 1'b0;
			end
			repeat (20) send(mk(ACT_STREAM, 8'($urandom_range(3)), 1'b0, -1));
		join
		set_weights($urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255));
		random_phase(NUM_RANDOM / 3);

		drain();
		$display("%0d query loads and %0d database rows sent, %0d row results checked",
			n_loads, n_beats_in, n_beats_out);
		$display("weight sets covered defaults, extremes and random values; %0d errors", errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/agla_pkg.sv
hdl/agla_ctrl.sv
hdl/agla_dp.sv
hdl/affine_gap_local_alignment_rows_top.sv
hdl/agla_checker.sv
sim/affine_gap_local_alignment_rows_top_tb.sv
